/* rtl/kshm_pkg.sv */
`default_nettype none

package kshm_pkg;

  // hash words a, b, c
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } kshm_words_t;

  // one step request for the shared mix unit
  typedef struct packed {
    logic       is_final;
    logic [2:0] step;
  } kshm_mix_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BMIX,
    S_FMIX,
    S_DIVGO,
    S_DIV,
    S_OUT
  } kshm_state_e;

  localparam logic [3:0] BlockBytes    = 4'd12;
  localparam logic [2:0] BlockMixLast  = 3'd5;
  localparam logic [2:0] FinalMixLast  = 3'd6;
  localparam logic [1:0] CfgHashSelect = 2'd0;
  localparam logic [1:0] CfgModulus    = 2'd1;

  function automatic logic [4:0] block_rot(input logic [2:0] step);
    logic [4:0] k;
    case (step)
      3'd0:    k = 5'd4;
      3'd1:    k = 5'd6;
      3'd2:    k = 5'd8;
      3'd3:    k = 5'd16;
      3'd4:    k = 5'd19;
      default: k = 5'd4;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] final_rot(input logic [2:0] step);
    logic [4:0] k;
    case (step)
      3'd0:    k = 5'd14;
      3'd1:    k = 5'd11;
      3'd2:    k = 5'd25;
      3'd3:    k = 5'd16;
      3'd4:    k = 5'd4;
      3'd5:    k = 5'd14;
      default: k = 5'd24;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/kshm_mix_unit.sv */
`default_nettype none

module kshm_mix_unit (
  input  kshm_pkg::kshm_words_t  words_i,
  input  kshm_pkg::kshm_mix_op_t op_i,
  output kshm_pkg::kshm_words_t  words_o
);
  import kshm_pkg::*;

  logic [1:0]  role;
  logic [31:0] x, y, z, rot, nx, ny;
  logic [4:0]  k;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    return (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

  always_comb begin
    case (op_i.step) inside
      3'd1, 3'd4: role = 2'd1;
      3'd2, 3'd5: role = 2'd2;
      default:    role = 2'd0;
    endcase

    x = words_i.a;
    y = words_i.c;
    z = words_i.b;
    unique case ({op_i.is_final, role})
      3'b000: begin x = words_i.a; y = words_i.c; z = words_i.b; end
      3'b001: begin x = words_i.b; y = words_i.a; z = words_i.c; end
      3'b010: begin x = words_i.c; y = words_i.b; z = words_i.a; end
      3'b100: begin x = words_i.c; y = words_i.b; z = words_i.a; end
      3'b101: begin x = words_i.a; y = words_i.c; z = words_i.b; end
      3'b110: begin x = words_i.b; y = words_i.a; z = words_i.c; end
      default: begin x = words_i.a; y = words_i.c; z = words_i.b; end
    endcase

    k   = op_i.is_final ? final_rot(op_i.step) : block_rot(op_i.step);
    rot = rotl(y, k);
    nx  = op_i.is_final ? ((x ^ y) - rot) : ((x - y) ^ rot);
    ny  = op_i.is_final ? y : (y + z);

    // x and y go back to the words they came from
    words_o = words_i;
    unique case ({op_i.is_final, role})
      3'b000, 3'b101: begin words_o.a = nx; words_o.c = ny; end
      3'b001, 3'b110: begin words_o.b = nx; words_o.a = ny; end
      3'b010, 3'b100: begin words_o.c = nx; words_o.b = ny; end
      default:        begin words_o.a = nx; words_o.c = ny; end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/kshm_divider.sv */
`default_nettype none

module kshm_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [30:0] divisor_i,
  output logic        done_o,
  output logic [30:0] remainder_o
);
  import kshm_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [30:0] rem_q, rem_d;
  logic [31:0] trial;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial  = {rem_q, quo_q[31]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = 31'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[30:0];
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign remainder_o = (divisor_i == '0) ? '0 : rem_q;

endmodule

`default_nettype wire

/* rtl/key_string_hash_mod.sv */
// key_string_hash_mod: streaming key hash with bucket index
// a byte beat is absorbed while idle; a twelfth byte in jenkins mode adds the block mix
// a last beat adds the final mix for a partial jenkins block, a state to start the serial
// divider, the division, a wait to see it done, then the load of the output register,
// and waits longer while a held result beat is stalled; the input stalls until then
// one shared mix step unit and one bit-per-cycle divider do this work
// reset (async, active low) clears words, position, config registers and handshake state
`default_nettype none

module key_string_hash_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  key_byte_i,
  input  logic        has_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] seed_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o,
  output logic [30:0] bucket_index_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_wdata_i
);
  import kshm_pkg::*;

  kshm_state_e  state_q, state_d;
  kshm_words_t  word_q, word_d, absorb_w, mix_w;
  kshm_mix_op_t mix_op;
  logic [3:0]   pos_q, pos_d, pos_cur, pos_new;
  logic [2:0]   step_q, step_d;
  logic         last_q, last_d;
  logic         hash_select_q;
  logic [30:0]  modulus_q;
  logic         out_valid_q, out_valid_d;
  logic [31:0]  hash_q;
  logic [30:0]  bucket_q;
  logic         in_beat, out_load, div_start, div_done, block_full;
  logic [31:0]  sx, lane;
  logic [30:0]  div_rem;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_select_q <= 1'b0;
      modulus_q     <= 31'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgHashSelect: hash_select_q <= cfg_wdata_i[0];
        CfgModulus:    modulus_q     <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // absorb one byte into the words
  always_comb begin
    absorb_w   = first_byte_i ? kshm_words_t'{a: seed_i, b: seed_i, c: seed_i} : word_q;
    pos_cur    = first_byte_i ? 4'd0 : pos_q;
    pos_new    = pos_cur;
    block_full = 1'b0;
    sx         = {{24{key_byte_i[7]}}, key_byte_i};
    lane       = '0;
    if (has_byte_i) begin
      if (pos_cur >= BlockBytes) begin
        pos_cur = 4'd0;
      end
      lane = sx << {pos_cur[1:0], 3'b000};
      if (!hash_select_q) begin
        if (pos_cur < 4'd4) begin
          absorb_w.a = absorb_w.a + lane;
        end else if (pos_cur < 4'd8) begin
          absorb_w.b = absorb_w.b + lane;
        end else begin
          absorb_w.c = absorb_w.c + lane;
        end
      end else begin
        // c*33 as shift and add
        absorb_w.c = {absorb_w.c[26:0], 5'b00000} + absorb_w.c + sx;
      end
      pos_new = pos_cur + 4'd1;
      if (pos_new == BlockBytes) begin
        pos_new    = 4'd0;
        block_full = !hash_select_q;
      end
    end
  end

  assign mix_op.is_final = (state_q == S_FMIX);
  assign mix_op.step     = step_q;

  kshm_mix_unit u_mix (
    .words_i (word_q),
    .op_i    (mix_op),
    .words_o (mix_w)
  );

  kshm_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (word_q.c),
    .divisor_i   (modulus_q),
    .done_o      (div_done),
    .remainder_o (div_rem)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    pos_d     = pos_q;
    step_d    = step_q;
    last_d    = last_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          word_d = absorb_w;
          last_d = last_byte_i;
          step_d = '0;
          pos_d  = last_byte_i ? 4'd0 : pos_new;
          if (block_full) begin
            state_d = S_BMIX;
          end else if (last_byte_i) begin
            // partial final block in jenkins mode gets the final mix
            state_d = (!hash_select_q && pos_new != 4'd0) ? S_FMIX : S_DIVGO;
          end
        end
      end
      S_BMIX: begin
        word_d = mix_w;
        step_d = step_q + 3'd1;
        if (step_q == BlockMixLast) begin
          step_d  = '0;
          state_d = last_q ? S_DIVGO : S_IDLE;
        end
      end
      S_FMIX: begin
        word_d = mix_w;
        step_d = step_q + 3'd1;
        if (step_q == FinalMixLast) begin
          step_d  = '0;
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register holds the result beat until taken
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      word_q      <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      pos_q       <= pos_d;
      step_q      <= step_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      hash_q   <= word_q.c;
      bucket_q <= div_rem;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hash_value_o   = hash_q;
  assign bucket_index_o = bucket_q;

  // a key end always leaves the block position at zero
  a_last_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && last_byte_i |=> pos_q == 4'd0)
    else $error("block position not cleared after key end");

  // position never leaves the block range
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> pos_q < BlockBytes)
    else $error("block position out of range");

  // the divider only finishes while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside of division state");

  // a delivered index is below the modulus
  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && modulus_q != '0 |-> bucket_index_o < modulus_q)
    else $error("bucket index not below modulus");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import kshm_pkg::*;

  // register indexes past the end of the map, written only to see them ignored
  localparam logic [1:0] CfgSpareLo = 2'd2;
  localparam logic [1:0] CfgSpareHi = 2'd3;
  // the block may still mix after the last result, so wait this long before writes
  localparam int SettleCycles = 64;
  // cycles with no beat on either channel before the run is called hung
  localparam int HangLimit = 4000;
  localparam int DirRows = 24;
  localparam int ItemsPerSet = 112;

  // one result: final word c and its bucket
  typedef struct packed {
    logic [31:0] hash;
    logic [30:0] bucket;
  } digest_t;

  // one row of the directed table: optional register setup, a beat, an optional typed result
  typedef struct packed {
    logic        reprog;
    logic        sel;
    logic [30:0] md;
    logic [7:0]  kb;
    logic        hb;
    logic        fb;
    logic        lb;
    logic [31:0] sd;
    logic        typed;
    logic [31:0] eh;
    logic [30:0] ei;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  key_byte_i = '0;
  logic        has_byte_i = 1'b0;
  logic        first_byte_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic [31:0] seed_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] hash_value_o;
  logic [30:0] bucket_index_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [30:0] cfg_wdata_i = '0;

  // own copy of the block's state and registers
  kshm_words_t hash_words;
  logic [3:0]  blk_pos;
  logic        sel_q;
  logic [30:0] mod_q;

  digest_t     pending_digests[$];
  digest_t     want;
  dir_row_t    dir_rows[DirRows];
  int          fail_count = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          idle_cycles = 0;

  key_string_hash_mod u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .key_byte_i     (key_byte_i),
    .has_byte_i     (has_byte_i),
    .first_byte_i   (first_byte_i),
    .last_byte_i    (last_byte_i),
    .seed_i         (seed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hash_value_o   (hash_value_o),
    .bucket_index_o (bucket_index_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned k);
    return (x << k) | (x >> (32 - k));
  endfunction

  // mix after each full 12-byte block
  function automatic kshm_words_t block_mix(input kshm_words_t w);
    logic [31:0] a, b, c;
    a = w.a; b = w.b; c = w.c;
    a -= c; a ^= rotl(c, 4);  c += b;
    b -= a; b ^= rotl(a, 6);  a += c;
    c -= b; c ^= rotl(b, 8);  b += a;
    a -= c; a ^= rotl(c, 16); c += b;
    b -= a; b ^= rotl(a, 19); a += c;
    c -= b; c ^= rotl(b, 4);  b += a;
    return '{a: a, b: b, c: c};
  endfunction

  // mix for a partial final block
  function automatic kshm_words_t final_mix(input kshm_words_t w);
    logic [31:0] a, b, c;
    a = w.a; b = w.b; c = w.c;
    c ^= b; c -= rotl(b, 14);
    a ^= c; a -= rotl(c, 11);
    b ^= a; b -= rotl(a, 25);
    c ^= b; c -= rotl(b, 16);
    a ^= c; a -= rotl(c, 4);
    b ^= a; b -= rotl(a, 14);
    c ^= b; c -= rotl(b, 24);
    return '{a: a, b: b, c: c};
  endfunction

  // fold one accepted beat into the hash words, give the digest on the last beat
  function automatic void advance_hash(input logic [7:0] kb, input logic hb, input logic fb,
                                       input logic lb, input logic [31:0] sd,
                                       output logic got, output digest_t res);
    logic [31:0] sx;
    logic [31:0] lane;
    logic [31:0] rem;
    logic [3:0]  pos;
    got = 1'b0;
    res = '0;
    if (fb) begin
      hash_words.a = sd;
      hash_words.b = sd;
      hash_words.c = sd;
      blk_pos = '0;
    end
    if (hb) begin
      // byte counts as a signed char
      sx = {{24{kb[7]}}, kb};
      pos = (blk_pos >= BlockBytes) ? 4'd0 : blk_pos;
      if (!sel_q) begin
        // little-endian lane within a, b or c
        lane = sx << {pos[1:0], 3'b000};
        if (pos < 4'd4) hash_words.a += lane;
        else if (pos < 4'd8) hash_words.b += lane;
        else hash_words.c += lane;
      end else begin
        hash_words.c = hash_words.c * 32'd33 + sx;
      end
      pos = pos + 4'd1;
      if (pos == BlockBytes) begin
        if (!sel_q) hash_words = block_mix(hash_words);
        pos = '0;
      end
      blk_pos = pos;
    end
    if (lb) begin
      // whole blocks and empty keys skip the final mix
      if (!sel_q && blk_pos != 4'd0) hash_words = final_mix(hash_words);
      blk_pos = '0;
      rem = (mod_q == '0) ? 32'd0 : hash_words.c % {1'b0, mod_q};
      res.hash = hash_words.c;
      res.bucket = rem[30:0];
      got = 1'b1;
    end
  endfunction

  // one input beat: random gaps, hold until accepted, then predict
  task automatic send_beat(input logic [7:0] kb, input logic hb, input logic fb,
                           input logic lb, input logic [31:0] sd,
                           input logic typed, input digest_t typed_res);
    logic    got;
    digest_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    key_byte_i   <= kb;
    has_byte_i   <= hb;
    first_byte_i <= fb;
    last_byte_i  <= lb;
    seed_i       <= sd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_hash(kb, hb, fb, lb, sd, got, res);
    if (got) pending_digests.insert(pending_digests.size(), typed ? typed_res : res);
    items_sent++;
  endtask

  // wait for every digest, then for any mixing that produces no result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write enable stays up across back-to-back writes; caller drops it
  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CfgHashSelect) sel_q = val[0];
    else if (idx == CfgModulus) mod_q = val;
  endtask

  task automatic program_regs(input logic sel, input logic [30:0] md);
    logic [30:0] val;
    val = 31'($urandom);
    val[0] = sel;
    write_reg(CfgHashSelect, val);
    write_reg(CfgModulus, md);
    // now and then poke an unmapped index with junk
    if ($urandom_range(1) == 0)
      write_reg($urandom_range(1) ? CfgSpareHi : CfgSpareLo, 31'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one random key: mostly well-formed, some broken framing, some pure noise
  task automatic send_key();
    int          len;
    int          kind;
    logic [31:0] sd;
    logic        fb;
    logic        lb;
    case ($urandom_range(7))
      0:       sd = 32'h0;
      1:       sd = 32'hFFFF_FFFF;
      default: sd = $urandom;
    endcase
    if ($urandom_range(99) < 10) begin
      send_beat(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), sd, 1'b0, '0);
    end else begin
      kind = $urandom_range(9);
      if (kind < 5) len = $urandom_range(11, 1);
      else if (kind < 7) len = 12 * $urandom_range(3, 1);
      else if (kind == 7) len = 0;
      else len = $urandom_range(40, 13);
      if (len == 0) begin
        // empty key
        send_beat(8'($urandom), 1'b0, 1'b1, 1'b1, sd, 1'b0, '0);
      end else begin
        for (int i = 0; i < len; i++) begin
          fb = (i == 0);
          lb = (i == len - 1);
          // broken framing: a key that never starts or never ends
          if ($urandom_range(39) == 0) begin
            if ($urandom_range(1)) fb = 1'b0;
            else lb = 1'b0;
          end
          send_beat(8'($urandom), ($urandom_range(15) != 0), fb, lb,
                    fb ? sd : 32'($urandom), 1'b0, '0);
        end
      end
    end
  endtask

  // output side: check each result beat, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digests.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result beat: hash %h bucket %h", hash_value_o, bucket_index_o);
        fail_count++;
      end else begin
        want = pending_digests.pop_front();
        if (want.hash !== hash_value_o || want.bucket !== bucket_index_o) begin
          if (fail_count < 10)
            $display("mismatch: hash exp %h got %h, bucket exp %h got %h",
                     want.hash, hash_value_o, want.bucket, bucket_index_o);
          fail_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // hang guard: counts cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HangLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // after reset: jenkins mode, modulus 1
    dir_rows[0]  = '{1'b0, 1'b0, 31'd0, 8'hFF, 1'b0, 1'b1, 1'b1, 32'hDEAD_BEEF,
                     1'b1, 32'hDEAD_BEEF, 31'd0};
    // no first beat: words carry over from the last key
    dir_rows[1]  = '{1'b0, 1'b0, 31'd0, 8'h00, 1'b0, 1'b0, 1'b1, 32'h0,
                     1'b1, 32'hDEAD_BEEF, 31'd0};
    // widest modulus, all-zero single byte key hashes to zero
    dir_rows[2]  = '{1'b1, 1'b0, 31'h7FFF_FFFF, 8'h00, 1'b1, 1'b1, 1'b1, 32'h0,
                     1'b1, 32'h0, 31'd0};
    dir_rows[3]  = '{1'b0, 1'b0, 31'd0, 8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,
                     1'b0, 32'h0, 31'd0};
    dir_rows[4]  = '{1'b0, 1'b0, 31'd0, 8'h80, 1'b1, 1'b1, 1'b1, 32'h0,
                     1'b0, 32'h0, 31'd0};
    dir_rows[5]  = '{1'b0, 1'b0, 31'd0, 8'h7F, 1'b1, 1'b1, 1'b1, 32'h1234_5678,
                     1'b0, 32'h0, 31'd0};
    // exactly one full block: block mix, no final mix
    dir_rows[6]  = '{1'b0, 1'b0, 31'd0, 8'h01, 1'b1, 1'b1, 1'b0, 32'hA5A5_A5A5,
                     1'b0, 32'h0, 31'd0};
    dir_rows[7]  = '{1'b0, 1'b0, 31'd0, 8'h80, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0, 31'd0};
    dir_rows[8]  = '{1'b0, 1'b0, 31'd0, 8'hFF, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0, 31'd0};
    dir_rows[9]  = '{1'b0, 1'b0, 31'd0, 8'h7F, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0, 31'd0};
    dir_rows[10] = '{1'b0, 1'b0, 31'd0, 8'h10, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0, 31'd0};
    dir_rows[11] = '{1'b0, 1'b0, 31'd0, 8'h20, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0, 31'd0};
    dir_rows[12] = '{1'b0, 1'b0, 31'd0, 8'hC3, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0, 31'd0};
    dir_rows[13] = '{1'b0, 1'b0, 31'd0, 8'h3C, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0, 31'd0};
    dir_rows[14] = '{1'b0, 1'b0, 31'd0, 8'h55, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0, 31'd0};
    dir_rows[15] = '{1'b0, 1'b0, 31'd0, 8'hAA, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0, 31'd0};
    dir_rows[16] = '{1'b0, 1'b0, 31'd0, 8'hFE, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0, 31'd0};
    dir_rows[17] = '{1'b0, 1'b0, 31'd0, 8'h81, 1'b1, 1'b0, 1'b1, 32'h0, 1'b0, 32'h0, 31'd0};
    // djb mode with zero modulus: bucket is 0
    dir_rows[18] = '{1'b1, 1'b1, 31'd0, 8'h80, 1'b1, 1'b1, 1'b1, 32'h0,
                     1'b1, 32'hFFFF_FF80, 31'd0};
    dir_rows[19] = '{1'b0, 1'b0, 31'd0, 8'h01, 1'b1, 1'b1, 1'b0, 32'd1, 1'b0, 32'h0, 31'd0};
    dir_rows[20] = '{1'b0, 1'b0, 31'd0, 8'hFF, 1'b1, 1'b0, 1'b1, 32'h0,
                     1'b1, 32'd1121, 31'd0};
    // mode change in the middle of a key
    dir_rows[21] = '{1'b1, 1'b0, 31'd1000, 8'h41, 1'b1, 1'b1, 1'b0, 32'h0BAD_F00D,
                     1'b0, 32'h0, 31'd0};
    dir_rows[22] = '{1'b1, 1'b1, 31'd1000, 8'h42, 1'b1, 1'b0, 1'b1, 32'h0,
                     1'b0, 32'h0, 31'd0};
    // empty beat ending a key that never started
    dir_rows[23] = '{1'b0, 1'b0, 31'd0, 8'h5A, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF,
                     1'b0, 32'h0, 31'd0};

    // model state after reset
    hash_words = '0;
    blk_pos    = '0;
    sel_q      = 1'b0;
    mod_q      = 31'd1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, no idling
    for (int r = 0; r < DirRows; r++) begin
      if (dir_rows[r].reprog) begin
        drain();
        program_regs(dir_rows[r].sel, dir_rows[r].md);
      end
      send_beat(dir_rows[r].kb, dir_rows[r].hb, dir_rows[r].fb, dir_rows[r].lb,
                dir_rows[r].sd, dir_rows[r].typed, '{hash: dir_rows[r].eh,
                bucket: dir_rows[r].ei});
    end

    // random keys: four idle mixes, several register settings in each
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 79; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      for (int s = 0; s < 4; s++) begin
        int          target;
        logic [30:0] md;
        drain();
        case ($urandom_range(5))
          0:       md = 31'd1;
          1:       md = 31'h7FFF_FFFF;
          2:       md = 31'd0;
          3:       md = 31'($urandom_range(100, 2));
          default: md = 31'($urandom);
        endcase
        program_regs(1'($urandom), md);
        target = items_sent + ItemsPerSet;
        while (items_sent < target) send_key();
      end
    end

    drain();
    if (fail_count == 0 && pending_digests.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* key_string_hash_mod.f */
rtl/kshm_pkg.sv
rtl/kshm_mix_unit.sv
rtl/kshm_divider.sv
rtl/key_string_hash_mod.sv
tb/sv/testbench.sv
